// ===== design/tkcsn_pkg.sv =====
package tkcsn_pkg;

    localparam int TOP_COUNT = 10;

    localparam int RAD_W  = 32;
    localparam int UNC_W  = 32;
    localparam int BAND_W = 3;

    localparam int CLOG_TOP = $clog2(TOP_COUNT);
    localparam int CNT_W    = $clog2(TOP_COUNT + 1);
    localparam int IDX_W    = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
    localparam int SUM_W    = RAD_W + CLOG_TOP;
    localparam int STEP_W   = $clog2(SUM_W);

    // noise mean: multiply by ceil(2^NSHIFT / TOP_COUNT), exact for any sum below
    // TOP_COUNT * 2^32; done as two half-width partial products
    localparam int NSHIFT  = RAD_W + 2 * CLOG_TOP;
    localparam int NREC_W  = NSHIFT - CLOG_TOP + 1;
    localparam logic [NREC_W-1:0] NREC =
        NREC_W'(((64'd1 << NSHIFT) + 64'(TOP_COUNT) - 64'd1) / 64'(TOP_COUNT));
    localparam int HALF_W  = (SUM_W + 1) / 2;
    localparam int PPROD_W = HALF_W + NREC_W;
    localparam int NPROD_W = PPROD_W + HALF_W;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic signed [RAD_W-1:0] rad;
        logic [UNC_W-1:0]        unc;
        logic [BAND_W-1:0]       band;
        logic                    last;
    } item_t;

endpackage

// ===== design/tkcsn_in_if.sv =====
interface tkcsn_in_if import tkcsn_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [RAD_W-1:0] radiance_sample;
    logic [UNC_W-1:0]        sample_uncertainty;
    logic [BAND_W-1:0]       band_tag;
    logic                    last_sample;

    modport source (output valid, radiance_sample, sample_uncertainty, band_tag, last_sample,
                    input ready);
    modport sink   (input valid, radiance_sample, sample_uncertainty, band_tag, last_sample,
                    output ready);
endinterface

// ===== design/tkcsn_out_if.sv =====
interface tkcsn_out_if import tkcsn_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [RAD_W-1:0] signal_average;
    logic [UNC_W-1:0]        noise_average;
    logic                    noise_valid;
    logic [BAND_W-1:0]       result_band;

    modport source (output valid, signal_average, noise_average, noise_valid, result_band,
                    input ready);
    modport sink   (input valid, signal_average, noise_average, noise_valid, result_band,
                    output ready);
endinterface

// ===== design/tkcsn_front.sv =====
module tkcsn_front import tkcsn_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    tkcsn_in_if.sink    samples,
    output logic        q_valid,
    input  logic        q_ready,
    output item_t       q_item
);

    item_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  fill_reg, fill_next;
    logic               push, pop;
    item_t              in_item;

    always_comb
    begin
        in_item.rad  = samples.radiance_sample;
        in_item.unc  = samples.sample_uncertainty;
        in_item.band = samples.band_tag;
        in_item.last = samples.last_sample;
    end

    assign samples.ready = (fill_reg != QCNT_W'(QDEPTH));
    assign q_valid       = (fill_reg != '0);
    assign q_item        = mem_reg[rd_ptr_reg];
    assign push          = samples.valid && samples.ready;
    assign pop           = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== design/tkcsn_div.sv =====
module tkcsn_div import tkcsn_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dsr_reg, dsr_next;
    logic [CNT_W:0]    trial;
    logic              fits;

    assign trial    = {rem_reg, dvd_reg[SUM_W-1]};
    assign fits     = (trial >= {1'b0, dsr_reg});
    assign done     = done_reg;
    assign quotient = dvd_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? CNT_W'(trial - {1'b0, dsr_reg}) : CNT_W'(trial);
            dvd_next  = {dvd_reg[SUM_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

endmodule

// ===== design/tkcsn_back.sv =====
module tkcsn_back import tkcsn_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    tkcsn_out_if.source results
);

    localparam logic [2:0] ST_RUN     = 3'd0;
    localparam logic [2:0] ST_SUM     = 3'd1;
    localparam logic [2:0] ST_DSIG_GO = 3'd2;
    localparam logic [2:0] ST_DSIG    = 3'd3;
    localparam logic [2:0] ST_NLO     = 3'd4;
    localparam logic [2:0] ST_OUT     = 3'd5;
    localparam logic [2:0] ST_NHI     = 3'd6;
    localparam logic [2:0] ST_NADD    = 3'd7;

    logic [2:0]              state_reg, state_next;
    logic signed [RAD_W-1:0] rad_reg [TOP_COUNT];
    logic signed [RAD_W-1:0] rad_next [TOP_COUNT];
    logic [UNC_W-1:0]        unc_reg [TOP_COUNT];
    logic [UNC_W-1:0]        unc_next [TOP_COUNT];
    logic signed [RAD_W-1:0] rad_up [TOP_COUNT];
    logic [UNC_W-1:0]        unc_up [TOP_COUNT];
    logic [TOP_COUNT-1:0]    ge, ge_prev;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        snap_reg, snap_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic signed [SUM_W-1:0] rsum_reg, rsum_next;
    logic [SUM_W-1:0]        usum_reg, usum_next;
    logic                    rneg_reg, rneg_next;
    logic [BAND_W-1:0]       band_reg, band_next;
    logic signed [RAD_W-1:0] sig_reg, sig_next;
    logic [UNC_W-1:0]        noise_reg, noise_next;
    logic [PPROD_W-1:0]      plo_reg, plo_next;
    logic [PPROD_W-1:0]      phi_reg, phi_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [RAD_W-1:0] out_sig_reg, out_sig_next;
    logic [UNC_W-1:0]        out_noise_reg, out_noise_next;
    logic                    out_nvalid_reg, out_nvalid_next;
    logic [BAND_W-1:0]       out_band_reg, out_band_next;
    logic                    take;
    logic                    nvalid;
    logic                    div_start;
    logic [SUM_W-1:0]        div_dividend;
    logic [CNT_W-1:0]        div_divisor;
    logic                    div_done;
    logic [SUM_W-1:0]        div_quot;
    logic [RAD_W-1:0]        quot_lo;
    logic [HALF_W-1:0]       mul_a;
    logic [PPROD_W-1:0]      mul_p;
    logic [NPROD_W-1:0]      nsum;

    assign q_ready = (state_reg == ST_RUN);
    assign take    = q_valid && q_ready;
    assign nvalid  = (snap_reg == CNT_W'(TOP_COUNT));
    assign quot_lo = div_quot[RAD_W-1:0];

    assign mul_a = (state_reg == ST_NHI) ? HALF_W'(usum_reg[SUM_W-1:HALF_W]) :
                                           usum_reg[HALF_W-1:0];
    assign mul_p = PPROD_W'(mul_a) * PPROD_W'(NREC);
    assign nsum  = NPROD_W'(plo_reg) + (NPROD_W'(phi_reg) << HALF_W);

    // parallel compare-and-shift insertion
    always_comb
    begin
        for (int i = 0; i < TOP_COUNT; i++)
        begin
            ge[i] = (CNT_W'(i) < count_reg) && (rad_reg[i] >= q_item.rad);
        end
        ge_prev[0] = 1'b1;
        rad_up[0]  = q_item.rad;
        unc_up[0]  = q_item.unc;
        for (int i = 1; i < TOP_COUNT; i++)
        begin
            ge_prev[i] = ge[i-1];
            rad_up[i]  = rad_reg[i-1];
            unc_up[i]  = unc_reg[i-1];
        end
        for (int i = 0; i < TOP_COUNT; i++)
        begin
            if (ge[i])
            begin
                rad_next[i] = rad_reg[i];
                unc_next[i] = unc_reg[i];
            end
            else if (ge_prev[i])
            begin
                rad_next[i] = q_item.rad;
                unc_next[i] = q_item.unc;
            end
            else
            begin
                rad_next[i] = rad_up[i];
                unc_next[i] = unc_up[i];
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        snap_next       = snap_reg;
        idx_next        = idx_reg;
        rsum_next       = rsum_reg;
        usum_next       = usum_reg;
        rneg_next       = rneg_reg;
        band_next       = band_reg;
        sig_next        = sig_reg;
        noise_next      = noise_reg;
        plo_next        = plo_reg;
        phi_next        = phi_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_sig_next    = out_sig_reg;
        out_noise_next  = out_noise_reg;
        out_nvalid_next = out_nvalid_reg;
        out_band_next   = out_band_reg;
        div_start       = 1'b0;
        div_dividend    = rsum_reg[SUM_W-1] ? SUM_W'(-rsum_reg) : SUM_W'(rsum_reg);
        div_divisor     = snap_reg;

        case (state_reg)
            ST_RUN:
            begin
                if (take)
                begin
                    if (count_reg != CNT_W'(TOP_COUNT))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (q_item.last)
                    begin
                        snap_next  = (count_reg != CNT_W'(TOP_COUNT)) ?
                                     count_reg + 1'b1 : count_reg;
                        count_next = '0;
                        idx_next   = '0;
                        rsum_next  = '0;
                        usum_next  = '0;
                        band_next  = q_item.band;
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                rsum_next = rsum_reg + SUM_W'(rad_reg[idx_reg]);
                usum_next = usum_reg + SUM_W'(unc_reg[idx_reg]);
                if (CNT_W'(idx_reg) == snap_reg - CNT_W'(1))
                begin
                    state_next = ST_DSIG_GO;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DSIG_GO:
            begin
                div_start  = 1'b1;
                rneg_next  = rsum_reg[SUM_W-1];
                state_next = ST_DSIG;
            end
            ST_DSIG:
            begin
                if (div_done)
                begin
                    sig_next = rneg_reg ? RAD_W'(-quot_lo) : RAD_W'(quot_lo);
                    if (nvalid)
                    begin
                        state_next = ST_NLO;
                    end
                    else
                    begin
                        noise_next = '0;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_NLO:
            begin
                plo_next   = mul_p;
                state_next = ST_NHI;
            end
            ST_NHI:
            begin
                phi_next   = mul_p;
                state_next = ST_NADD;
            end
            ST_NADD:
            begin
                noise_next = nsum[NSHIFT+UNC_W-1:NSHIFT];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_sig_next    = sig_reg;
                    out_noise_next  = noise_reg;
                    out_nvalid_next = nvalid;
                    out_band_next   = band_reg;
                    state_next      = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    tkcsn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < TOP_COUNT; i++)
            begin
                rad_reg[i] <= rad_next[i];
                unc_reg[i] <= unc_next[i];
            end
        end
        snap_reg       <= snap_next;
        idx_reg        <= idx_next;
        rsum_reg       <= rsum_next;
        usum_reg       <= usum_next;
        rneg_reg       <= rneg_next;
        band_reg       <= band_next;
        sig_reg        <= sig_next;
        noise_reg      <= noise_next;
        plo_reg        <= plo_next;
        phi_reg        <= phi_next;
        out_sig_reg    <= out_sig_next;
        out_noise_reg  <= out_noise_next;
        out_nvalid_reg <= out_nvalid_next;
        out_band_reg   <= out_band_next;
    end

    assign results.valid          = out_valid_reg;
    assign results.signal_average = out_sig_reg;
    assign results.noise_average  = out_noise_reg;
    assign results.noise_valid    = out_nvalid_reg;
    assign results.result_band    = out_band_reg;

endmodule

// ===== design/top_k_continuum_signal_noise.sv =====
// Top-k continuum signal and noise estimator.
// samples: one spectral sample per transaction (radiance Q16.16 signed,
//   uncertainty Q16.16 unsigned, band tag, last flag). Up to four samples
//   queue ahead of the sorter.
// results: one transaction per band, after the sample flagged last.
// The sorter keeps the TOP_COUNT largest radiances in descending order and
// inserts one sample per cycle while it is not closing out a band.
// On the last sample the sorter stops taking samples for the close-out:
//   summation of the kept samples, a setup state, a one-bit-per-cycle
//   divider for the signal, reciprocal multiplication for the noise (low
//   partial product, high partial product, sum) when at least TOP_COUNT
//   samples were seen, then loading of the output register.
// The result sits in an output register; a stalled receiver holds it there
// and the sorter keeps taking the next band's samples, waiting only if a
// second result is ready before the first is taken.
// Reset empties the queue, clears the kept count and drops any result.
module top_k_continuum_signal_noise import tkcsn_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    tkcsn_in_if.sink    samples,
    tkcsn_out_if.source results
);

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    tkcsn_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    tkcsn_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .results (results)
    );

    a_noise_zero_when_invalid: assert property (
        @(posedge clk) disable iff (!rst_n)
        results.valid && !results.noise_valid |-> results.noise_average == '0
    ) else $error("noise_average nonzero while noise_valid is clear");

    a_stop_after_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_valid && q_ready && q_item.last |=> !q_ready
    ) else $error("sorter took a sample during close-out");

endmodule
